@@ src/twt_pkg.sv @@
// twt_pkg: shared constants, operation and status codes, and the packet types
// that pass between the tag table cells and the top level
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package twt_pkg;

    localparam int SLOTS      = 16;
    localparam int TAG_W      = 48;
    localparam int KIND_W     = 3;
    localparam int SLOT_IN_W  = 8;
    localparam int STATUS_W   = 3;
    localparam int SLOT_OUT_W = 4;
    localparam int COUNT_W    = 5;
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W      = $clog2(SLOTS + 1);

    localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_GET    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FIND   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CHECK  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EXISTS    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BAD_TAG   = 3'd5;

    typedef struct packed {
        logic                 vld;
        logic [KIND_W-1:0]    kind;
        logic [TAG_W-1:0]     tag;
        logic [SLOT_IN_W-1:0] slot;
        logic                 dup_hit;
        logic [SLOT_W-1:0]    dup_idx;
        logic                 emp_hit;
        logic [SLOT_W-1:0]    emp_idx;
        logic [TAG_W-1:0]     sel_tag;
    } t_pkt;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] idx;
        logic [TAG_W-1:0]  data;
    } t_wr;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [TAG_W-1:0]      tag_out;
        logic [SLOT_OUT_W-1:0] slot_out;
        logic                  found;
        logic                  is_free;
        logic [COUNT_W-1:0]    count;
    } t_res;

endpackage

`default_nettype wire

@@ src/tag_whitelist_table.sv @@
// tag_whitelist_table: the packet walks through the chain of SLOTS cells, one cell
// per cycle, then the result is registered in a pending stage and an output stage;
// a new transaction is taken only once the previous result has moved to the output
// synchronous active-low reset empties every slot, zeroes the count and
// drops all valid flags
// depends on twt_pkg and twt_cell
`timescale 1ns / 1ps
`default_nettype none

module tag_whitelist_table (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output      logic                          o_in_stall,
    input  wire logic [twt_pkg::KIND_W-1:0]    i_kind,
    input  wire logic [twt_pkg::TAG_W-1:0]     i_tag,
    input  wire logic [twt_pkg::SLOT_IN_W-1:0] i_slot,
    output      logic                          o_out_valid,
    input  wire logic                          i_out_stall,
    output      logic [twt_pkg::STATUS_W-1:0]  o_status,
    output      logic [twt_pkg::TAG_W-1:0]     o_tag_out,
    output      logic [twt_pkg::SLOT_OUT_W-1:0] o_slot_out,
    output      logic                          o_found,
    output      logic                          o_is_free,
    output      logic [twt_pkg::COUNT_W-1:0]   o_occupied_count
);

    twt_pkg::t_pkt w_pkt [0:twt_pkg::SLOTS];
    twt_pkg::t_pkt w_head;
    twt_pkg::t_wr  w_wr;
    logic [twt_pkg::SLOTS-1:0] w_vld;

    logic                      r_inflight;
    logic                      r_pend_vld;
    twt_pkg::t_res             r_pend;
    logic                      r_out_vld;
    twt_pkg::t_res             r_out;
    logic [twt_pkg::CNT_W-1:0] r_occ;

    twt_pkg::t_res             n_res;
    logic [twt_pkg::CNT_W-1:0] n_occ;
    twt_pkg::t_pkt             w_tail;
    logic                      w_in_acc;
    logic                      w_out_load;
    logic                      w_slot_ok;
    logic                      w_sel_empty;
    logic                      w_tag_zero;

    assign w_in_acc   = i_in_valid && !r_inflight;
    assign o_in_stall = r_inflight;

    always_comb begin
        w_head         = '0;
        w_head.vld     = w_in_acc;
        w_head.kind    = i_kind;
        w_head.tag     = i_tag;
        w_head.slot    = i_slot;
    end

    assign w_pkt[0] = w_head;

    for (genvar k = 0; k < twt_pkg::SLOTS; k++) begin : g_cell
        twt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (twt_pkg::SLOT_W'(k)),
            .i_pkt   (w_pkt[k]),
            .i_wr    (w_wr),
            .o_pkt   (w_pkt[k+1])
        );
        assign w_vld[k] = w_pkt[k+1].vld;
    end

    assign w_tail      = w_pkt[twt_pkg::SLOTS];
    assign w_slot_ok   = w_tail.slot < twt_pkg::SLOT_IN_W'(twt_pkg::SLOTS);
    assign w_sel_empty = w_tail.sel_tag == '0;
    assign w_tag_zero  = w_tail.tag == '0;

    // result and table update from the packet leaving the last cell
    always_comb begin
        n_res  = '0;
        n_occ  = r_occ;
        w_wr   = '0;
        n_res.status = twt_pkg::ST_OK;
        case (w_tail.kind)
            twt_pkg::KIND_ADD: begin
                if (w_tag_zero) begin
                    n_res.status = twt_pkg::ST_BAD_TAG;
                end else if (w_tail.dup_hit) begin
                    n_res.status   = twt_pkg::ST_EXISTS;
                    n_res.slot_out = twt_pkg::SLOT_OUT_W'(w_tail.dup_idx);
                end else if (w_tail.emp_hit) begin
                    n_res.slot_out = twt_pkg::SLOT_OUT_W'(w_tail.emp_idx);
                    n_occ          = r_occ + twt_pkg::CNT_W'(1);
                    w_wr.en        = w_tail.vld;
                    w_wr.idx       = w_tail.emp_idx;
                    w_wr.data      = w_tail.tag;
                end else begin
                    n_res.status = twt_pkg::ST_FULL;
                end
            end
            twt_pkg::KIND_REMOVE: begin
                if (!w_slot_ok) begin
                    n_res.status = twt_pkg::ST_BAD_INDEX;
                end else if (w_sel_empty) begin
                    n_res.status = twt_pkg::ST_NOT_FOUND;
                end else begin
                    if (r_occ != '0) begin
                        n_occ = r_occ - twt_pkg::CNT_W'(1);
                    end
                    w_wr.en   = w_tail.vld;
                    w_wr.idx  = twt_pkg::SLOT_W'(w_tail.slot);
                    w_wr.data = '0;
                end
            end
            twt_pkg::KIND_GET: begin
                if (!w_slot_ok) begin
                    n_res.status = twt_pkg::ST_BAD_INDEX;
                end else if (w_sel_empty) begin
                    n_res.status = twt_pkg::ST_NOT_FOUND;
                end else begin
                    n_res.tag_out = w_tail.sel_tag;
                end
            end
            twt_pkg::KIND_FIND: begin
                if (w_tag_zero) begin
                    n_res.status = twt_pkg::ST_BAD_TAG;
                end else if (w_tail.dup_hit) begin
                    n_res.found    = 1'b1;
                    n_res.slot_out = twt_pkg::SLOT_OUT_W'(w_tail.dup_idx);
                end else begin
                    n_res.status = twt_pkg::ST_NOT_FOUND;
                end
            end
            twt_pkg::KIND_CHECK: begin
                if (!w_slot_ok) begin
                    n_res.status = twt_pkg::ST_BAD_INDEX;
                end else begin
                    n_res.is_free = w_sel_empty;
                end
            end
            default: begin
                n_res.status = twt_pkg::ST_OK;
            end
        endcase
        n_res.count = twt_pkg::COUNT_W'(n_occ);
    end

    assign w_out_load = r_pend_vld && (!r_out_vld || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            r_occ      <= '0;
        end else begin
            if (w_in_acc) begin
                r_inflight <= 1'b1;
            end else if (w_out_load) begin
                r_inflight <= 1'b0;
            end
            if (w_tail.vld) begin
                r_pend_vld <= 1'b1;
                r_occ      <= n_occ;
            end else if (w_out_load) begin
                r_pend_vld <= 1'b0;
            end
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tail.vld) begin
            r_pend <= n_res;
        end
        if (w_out_load) begin
            r_out <= r_pend;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_status         = r_out.status;
    assign o_tag_out        = r_out.tag_out;
    assign o_slot_out       = r_out.slot_out;
    assign o_found          = r_out.found;
    assign o_is_free        = r_out.is_free;
    assign o_occupied_count = r_out.count;

`ifndef SYNTHESIS
    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= twt_pkg::CNT_W'(twt_pkg::SLOTS))
        else $error("occupied count above slot count");

    a_occ_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ == $past(r_occ)) || (r_occ == $past(r_occ) + twt_pkg::CNT_W'(1)) ||
        (r_occ == $past(r_occ) - twt_pkg::CNT_W'(1)))
        else $error("occupied count moved by more than one");

    a_one_pkt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_vld))
        else $error("more than one packet in the cell chain");

    a_pend_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_vld || (w_vld != '0)) |-> r_inflight)
        else $error("transaction in progress without in-flight flag");

    a_tail_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tail.vld |=> r_pend_vld)
        else $error("result lost at end of cell chain");
`endif

endmodule

`default_nettype wire

@@ src/twt_cell.sv @@
// twt_cell: one slot of the tag table, holds one tag and folds its compare
// results into the packet that passes through it each cycle
// depends on twt_pkg
`timescale 1ns / 1ps
`default_nettype none

module twt_cell (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [twt_pkg::SLOT_W-1:0] i_idx,
    input  wire twt_pkg::t_pkt             i_pkt,
    input  wire twt_pkg::t_wr              i_wr,
    output      twt_pkg::t_pkt             o_pkt
);

    logic [twt_pkg::TAG_W-1:0] r_tag;
    twt_pkg::t_pkt             r_pkt;
    twt_pkg::t_pkt             n_pkt;

    always_comb begin
        n_pkt = i_pkt;
        if (!i_pkt.dup_hit && (r_tag == i_pkt.tag)) begin
            n_pkt.dup_hit = 1'b1;
            n_pkt.dup_idx = i_idx;
        end
        if (!i_pkt.emp_hit && (r_tag == '0)) begin
            n_pkt.emp_hit = 1'b1;
            n_pkt.emp_idx = i_idx;
        end
        if (i_pkt.slot == twt_pkg::SLOT_IN_W'(i_idx)) begin
            n_pkt.sel_tag = r_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else if (i_wr.en && (i_wr.idx == i_idx)) begin
            r_tag <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt.vld <= 1'b0;
        end else begin
            r_pkt <= n_pkt;
        end
    end

    assign o_pkt = r_pkt;

endmodule

`default_nettype wire

@@ bench/twt_checker.sv @@
// twt_checker: watches both channels of tag_whitelist_table, keeps its own copy of the
// tag table, predicts every result and compares it field by field
// depends on twt_pkg
`timescale 1ns / 1ps

module twt_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    input  wire logic                           i_in_stall,
    input  wire logic [twt_pkg::KIND_W-1:0]     i_kind,
    input  wire logic [twt_pkg::TAG_W-1:0]      i_tag,
    input  wire logic [twt_pkg::SLOT_IN_W-1:0]  i_slot,
    input  wire logic                           i_out_valid,
    input  wire logic                           i_out_stall,
    input  wire logic [twt_pkg::STATUS_W-1:0]   i_status,
    input  wire logic [twt_pkg::TAG_W-1:0]      i_tag_out,
    input  wire logic [twt_pkg::SLOT_OUT_W-1:0] i_slot_out,
    input  wire logic                           i_found,
    input  wire logic                           i_is_free,
    input  wire logic [twt_pkg::COUNT_W-1:0]    i_occupied_count,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    import twt_pkg::*;

    logic [TAG_W-1:0] slot_tags [SLOTS];
    int unsigned      used_slots;
    t_res             result_q [$];
    t_res             got;
    t_res             want;
    int               fail_cnt = 0;
    int               waiting  = 0;

    assign o_fail_count = fail_cnt;
    assign o_pending    = waiting;

    function automatic int slot_holding(input logic [TAG_W-1:0] t);
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_tags[i] == t) return i;
        end
        return SLOTS;
    endfunction

    // applies one operation to the shadow table and returns the result it gives
    function automatic t_res table_op(input logic [KIND_W-1:0] kind,
                                      input logic [TAG_W-1:0] tag,
                                      input logic [SLOT_IN_W-1:0] slot);
        t_res r;
        int   idx;
        r = '0;
        r.status = ST_OK;
        case (kind)
            KIND_ADD: begin
                if (tag == '0) begin
                    r.status = ST_BAD_TAG;
                end else begin
                    idx = slot_holding(tag);
                    if (idx < SLOTS) begin
                        r.status   = ST_EXISTS;
                        r.slot_out = idx[SLOT_OUT_W-1:0];
                    end else begin
                        idx = slot_holding('0);
                        if (idx < SLOTS) begin
                            slot_tags[idx] = tag;
                            used_slots++;
                            r.slot_out = idx[SLOT_OUT_W-1:0];
                        end else begin
                            r.status = ST_FULL;
                        end
                    end
                end
            end
            KIND_REMOVE: begin
                if (slot >= SLOTS) begin
                    r.status = ST_BAD_INDEX;
                end else if (slot_tags[slot] == '0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    slot_tags[slot] = '0;
                    if (used_slots > 0) used_slots--;
                end
            end
            KIND_GET: begin
                if (slot >= SLOTS) begin
                    r.status = ST_BAD_INDEX;
                end else if (slot_tags[slot] == '0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    r.tag_out = slot_tags[slot];
                end
            end
            KIND_FIND: begin
                if (tag == '0) begin
                    r.status = ST_BAD_TAG;
                end else begin
                    idx = slot_holding(tag);
                    if (idx < SLOTS) begin
                        r.found    = 1'b1;
                        r.slot_out = idx[SLOT_OUT_W-1:0];
                    end else begin
                        r.status = ST_NOT_FOUND;
                    end
                end
            end
            KIND_CHECK: begin
                if (slot >= SLOTS) begin
                    r.status = ST_BAD_INDEX;
                end else begin
                    r.is_free = (slot_tags[slot] == '0);
                end
            end
            default: begin
            end
        endcase
        r.count = used_slots[COUNT_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (slot_tags[i]) slot_tags[i] = '0;
            used_slots = 0;
            result_q.delete();
            waiting = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got.status   = i_status;
                got.tag_out  = i_tag_out;
                got.slot_out = i_slot_out;
                got.found    = i_found;
                got.is_free  = i_is_free;
                got.count    = i_occupied_count;
                if (result_q.size() == 0) begin
                    if (fail_cnt < 10) begin
                        $display("%0t twt_checker: result with none expected, status %0d count %0d",
                                 $time, got.status, got.count);
                    end
                    fail_cnt++;
                end else begin
                    want = result_q.pop_front();
                    waiting--;
                    if (got !== want) begin
                        if (fail_cnt < 10) begin
                            $display("%0t twt_checker: mismatch exp/got status %0d/%0d tag_out %h/%h",
                                     $time, want.status, got.status, want.tag_out, got.tag_out);
                            $display("    slot_out %0d/%0d found %0d/%0d is_free %0d/%0d count %0d/%0d",
                                     want.slot_out, got.slot_out, want.found, got.found,
                                     want.is_free, got.is_free, want.count, got.count);
                        end
                        fail_cnt++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                result_q.push_back(table_op(i_kind, i_tag, i_slot));
                waiting++;
            end
        end
    end

endmodule

@@ bench/tb_top.sv @@
// tb_top: drives tag_whitelist_table with directed and random table operations under
// random idling on both channels; verdict from the checker's count or an idle watchdog
// depends on twt_pkg, tag_whitelist_table and twt_checker
`timescale 1ns / 1ps

module tb_top;

    import twt_pkg::*;

    localparam int ITEMS    = 2000;
    localparam int WATCHDOG = 4000;

    localparam logic [KIND_W-1:0] KIND_SPARE_5 = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

    typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} t_phase;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_in_valid  = 1'b0;
    logic [KIND_W-1:0]      i_kind      = '0;
    logic [TAG_W-1:0]       i_tag       = '0;
    logic [SLOT_IN_W-1:0]   i_slot      = '0;
    logic                   i_out_stall = 1'b0;
    logic                   o_in_stall;
    logic                   o_out_valid;
    logic [STATUS_W-1:0]    o_status;
    logic [TAG_W-1:0]       o_tag_out;
    logic [SLOT_OUT_W-1:0]  o_slot_out;
    logic                   o_found;
    logic                   o_is_free;
    logic [COUNT_W-1:0]     o_occupied_count;
    int                     fail_count;
    int                     pending;

    logic                   calm = 1'b0;
    int                     stall_hold = 0;
    int                     idle_cycles = 0;
    logic [TAG_W-1:0]       tag_pool [32];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    tag_whitelist_table u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_kind           (i_kind),
        .i_tag            (i_tag),
        .i_slot           (i_slot),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_tag_out        (o_tag_out),
        .o_slot_out       (o_slot_out),
        .o_found          (o_found),
        .o_is_free        (o_is_free),
        .o_occupied_count (o_occupied_count)
    );

    twt_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_kind           (i_kind),
        .i_tag            (i_tag),
        .i_slot           (i_slot),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_status         (o_status),
        .i_tag_out        (o_tag_out),
        .i_slot_out       (o_slot_out),
        .i_found          (o_found),
        .i_is_free        (o_is_free),
        .i_occupied_count (o_occupied_count),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // result-side stall in bursts, mostly short
    always @(negedge i_clk) begin
        if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
        end else begin
            i_out_stall <= !calm && ($urandom_range(0, 2) == 0);
            stall_hold  <= ($urandom_range(0, 99) < 95) ? $urandom_range(0, 3)
                                                        : $urandom_range(20, 60);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG) begin
            $display("tb_top: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [TAG_W-1:0] rand_tag();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[TAG_W-1:0];
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [SLOT_IN_W-1:0] pick_slot();
        if ($urandom_range(0, 99) < 88) return SLOT_IN_W'($urandom_range(0, SLOTS - 1));
        return SLOT_IN_W'($urandom_range(SLOTS, 255));
    endfunction

    function automatic logic [TAG_W-1:0] pick_tag();
        int r;
        logic [TAG_W-1:0] t;
        r = $urandom_range(0, 99);
        if (r < 8) return '0;
        if (r < 65) return tag_pool[$urandom_range(0, 31)];
        t = rand_tag();
        tag_pool[$urandom_range(0, 31)] = t;
        return t;
    endfunction

    function automatic logic [KIND_W-1:0] pick_kind(input t_phase ph);
        int r;
        r = $urandom_range(0, 99);
        case (ph)
            PH_FILL: begin
                if (r < 70) return KIND_ADD;
                if (r < 80) return KIND_FIND;
                if (r < 88) return KIND_GET;
                if (r < 94) return KIND_CHECK;
                if (r < 98) return KIND_REMOVE;
            end
            PH_DRAIN: begin
                if (r < 50) return KIND_REMOVE;
                if (r < 60) return KIND_ADD;
                if (r < 72) return KIND_FIND;
                if (r < 84) return KIND_GET;
                if (r < 96) return KIND_CHECK;
            end
            default: begin
                if (r < 25) return KIND_ADD;
                if (r < 45) return KIND_REMOVE;
                if (r < 65) return KIND_FIND;
                if (r < 80) return KIND_GET;
                if (r < 95) return KIND_CHECK;
            end
        endcase
        case ($urandom_range(0, 2))
            0: return KIND_SPARE_5;
            1: return KIND_SPARE_6;
            default: return KIND_SPARE_7;
        endcase
    endfunction

    // one transaction on the request side, with an optional idle gap first
    task automatic push_op(input logic [KIND_W-1:0] k, input logic [TAG_W-1:0] t,
                           input logic [SLOT_IN_W-1:0] s);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            i_kind     <= KIND_W'($urandom_range(0, 7));
            i_tag      <= rand_tag();
            i_slot     <= SLOT_IN_W'($urandom_range(0, 255));
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= k;
        i_tag      <= t;
        i_slot     <= s;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    initial begin
        int     sent;
        int     len;
        t_phase ph;
        logic [KIND_W-1:0] k;

        foreach (tag_pool[i]) tag_pool[i] = rand_tag();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: invalid tags, empty and out-of-range slots, spare kinds, basic flow
        push_op(KIND_FIND,    '0, '0);
        push_op(KIND_ADD,     '0, 8'hFF);
        push_op(KIND_GET,     '1, 8'd0);
        push_op(KIND_REMOVE,  '1, SLOT_IN_W'(SLOTS - 1));
        push_op(KIND_CHECK,   '0, 8'd0);
        push_op(KIND_CHECK,   '0, SLOT_IN_W'(SLOTS));
        push_op(KIND_GET,     '0, 8'hFF);
        push_op(KIND_REMOVE,  '0, SLOT_IN_W'(SLOTS));
        push_op(KIND_SPARE_5, '1, 8'hFF);
        push_op(KIND_SPARE_6, '0, 8'd0);
        push_op(KIND_SPARE_7, '1, 8'hFF);
        push_op(KIND_ADD,     '1, 8'd0);
        push_op(KIND_ADD,     48'h1, 8'd0);
        push_op(KIND_ADD,     '1, 8'd0);
        push_op(KIND_FIND,    '1, 8'd0);
        push_op(KIND_FIND,    48'h1, 8'd0);
        push_op(KIND_FIND,    48'h8000_0000_0000, 8'd0);
        push_op(KIND_GET,     '0, 8'd0);
        push_op(KIND_CHECK,   '0, 8'd0);
        push_op(KIND_REMOVE,  '0, 8'd0);
        push_op(KIND_ADD,     48'h8000_0000_0000, 8'd0);
        push_op(KIND_GET,     '0, 8'd1);
        push_op(KIND_REMOVE,  '0, 8'd1);
        push_op(KIND_REMOVE,  '0, 8'd0);

        sent = 0;
        while (sent < ITEMS) begin
            ph   = t_phase'($urandom_range(0, 2));
            calm = ($urandom_range(0, 3) == 0);
            len  = $urandom_range(15, 60);
            tag_pool[$urandom_range(0, 31)] = rand_tag();
            for (int j = 0; j < len && sent < ITEMS; j++) begin
                k = pick_kind(ph);
                push_op(k, pick_tag(), pick_slot());
                sent++;
            end
        end
        calm = 1'b0;

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/twt_pkg.sv
src/twt_cell.sv
src/tag_whitelist_table.sv
bench/twt_checker.sv
bench/tb_top.sv
